[design/tsa_pkg.sv]
// Package for the texture slot allocator.
// Holds the request and status codes, the control state and the cell chain types.
// No dependencies.
package tsa_pkg;

    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_LOOKUP = 2'd1,
        ACT_END    = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        STS_HIT      = 3'd0,
        STS_PLACED   = 3'd1,
        STS_REPLACED = 3'd2,
        STS_MISS     = 3'd3,
        STS_FRAME    = 3'd4
    } t_status;

    typedef enum logic {
        ST_IDLE,
        ST_RESOLVE
    } t_state;

    // Running flags handed from one cell to the next, lowest slot first.
    typedef struct packed {
        logic hit_seen;
        logic empty_seen;
        logic free_seen;
    } t_chain;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic capture;
        logic resolve;
        logic do_add;
        logic do_end;
        logic any_hit;
        logic any_empty;
    } t_cmd;

endpackage

[design/tsa_cell.sv]
// One slot of the allocator: valid mark, resource id, reserved mark.
// Compares the broadcast id, then picks itself by the priority chain.
// Depends on tsa_pkg.
module tsa_cell #(
    parameter int IDX_W    = 4,
    parameter int CELL_IDX = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tsa_pkg::t_cmd        i_cmd,
    input  logic [31:0]          i_cmp_id,
    input  logic [31:0]          i_wr_id,
    input  tsa_pkg::t_chain      i_chain,
    input  logic [IDX_W-1:0]     i_idx,
    output tsa_pkg::t_chain      o_chain,
    output logic [IDX_W-1:0]     o_idx
);
    import tsa_pkg::*;

    logic        r_valid;
    logic        r_reserved;
    logic [31:0] r_resource;
    logic        r_hit;
    logic        r_empty;
    logic        r_free;

    logic sel_hit;
    logic sel_empty;
    logic sel_repl;
    logic sel_place;

    always_comb begin
        sel_hit   = r_hit && !i_chain.hit_seen;
        sel_empty = !i_cmd.any_hit && r_empty && !i_chain.empty_seen;
        sel_repl  = !i_cmd.any_hit && !i_cmd.any_empty && r_free && !i_chain.free_seen;
        sel_place = i_cmd.do_add && (sel_empty || sel_repl);

        o_chain.hit_seen   = i_chain.hit_seen   || r_hit;
        o_chain.empty_seen = i_chain.empty_seen || r_empty;
        o_chain.free_seen  = i_chain.free_seen  || r_free;

        o_idx = (sel_hit || sel_place) ? IDX_W'(CELL_IDX) : i_idx;
    end

    // match flags taken at the accept edge
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_hit   <= r_valid && (r_resource == i_cmp_id);
            r_empty <= !r_valid;
            r_free  <= !r_reserved;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_reserved <= 1'b0;
        end else if (i_cmd.resolve) begin
            if (i_cmd.do_end) begin
                r_reserved <= 1'b0;
            end else if (i_cmd.do_add && sel_hit) begin
                r_reserved <= 1'b1;
            end else if (sel_place) begin
                r_valid    <= 1'b1;
                r_reserved <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.resolve && sel_place) begin
            r_resource <= i_wr_id;
        end
    end

endmodule

[design/texture_slot_allocator.sv]
// Top level of the texture slot allocator: controller, result register
// and the row of slot cells. Depends on tsa_pkg and tsa_cell.
//
//  channel  dir  fields
//  s_axis   in   tdata: resource_id[31:0]; tuser: action[1:0]
//  m_axis   out  tdata: slot_index[3:0], zero pad[7:4]; tuser: status[2:0]
//
// Each transaction is handled by the accept edge, which registers the id compare
// in every cell, and the following resolve edge, which resolves the priority chain over SLOTS-1 cells,
// updates the table and loads the result register.
// Reset (synchronous, active low) clears all valid and reserved marks.
// A stalled result holds in its register; input is taken again once it drains.
module texture_slot_allocator #(
    parameter int SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // resource_id[31:0]
    input  logic [1:0]  s_axis_tuser,  // action[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // slot_index[3:0], zero[7:4]
    output logic [2:0]  m_axis_tuser   // status[2:0]
);
    import tsa_pkg::*;

    localparam int IDX_W = (SLOTS > 2) ? $clog2(SLOTS) : 1;

    t_state          r_state;
    t_state          n_state;
    logic [1:0]      r_action;
    logic [31:0]     r_id;
    logic            r_out_valid;
    logic [3:0]      r_out_idx;
    t_status         r_out_status;

    logic            accept;
    logic            resolve;
    t_cmd            cmd;
    t_chain          w_chain [SLOTS];
    logic [IDX_W-1:0] w_idx  [SLOTS];
    t_chain          chain_end;
    logic [IDX_W+3:0] idx_ext;
    logic [3:0]      res_idx;
    t_status         res_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        s_axis_tready = 1'b0;
        resolve       = 1'b0;
        n_state       = r_state;
        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready = !r_out_valid || m_axis_tready;
                if (s_axis_tvalid && s_axis_tready) begin
                    n_state = ST_RESOLVE;
                end
            end
            ST_RESOLVE: begin
                resolve = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        accept = s_axis_tvalid && s_axis_tready;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action <= s_axis_tuser;
            r_id     <= s_axis_tdata;
        end
    end

    assign chain_end = w_chain[SLOTS-1];

    always_comb begin
        cmd.capture   = accept;
        cmd.resolve   = resolve;
        cmd.do_add    = (r_action == ACT_ADD);
        cmd.do_end    = (r_action == ACT_END);
        cmd.any_hit   = chain_end.hit_seen;
        cmd.any_empty = chain_end.empty_seen;
    end

    assign w_chain[0] = '0;
    assign w_idx[0]   = '0;

    for (genvar k = 1; k < SLOTS; k++) begin : g_cell
        tsa_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (k)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_cmd    (cmd),
            .i_cmp_id (s_axis_tdata),
            .i_wr_id  (r_id),
            .i_chain  (w_chain[k-1]),
            .i_idx    (w_idx[k-1]),
            .o_chain  (w_chain[k]),
            .o_idx    (w_idx[k])
        );
    end

    assign idx_ext = {4'b0000, w_idx[SLOTS-1]};

    always_comb begin
        res_idx    = 4'd0;
        res_status = STS_MISS;
        unique case (r_action)
            ACT_ADD: begin
                res_idx = idx_ext[3:0];
                priority if (chain_end.hit_seen) begin
                    res_status = STS_HIT;
                end else if (chain_end.empty_seen) begin
                    res_status = STS_PLACED;
                end else if (chain_end.free_seen) begin
                    res_status = STS_REPLACED;
                end else begin
                    res_status = STS_MISS;
                end
            end
            ACT_LOOKUP: begin
                res_idx    = idx_ext[3:0];
                res_status = chain_end.hit_seen ? STS_HIT : STS_MISS;
            end
            ACT_END: begin
                res_status = STS_FRAME;
            end
            default: begin
                res_status = STS_MISS;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (resolve) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (resolve) begin
            r_out_idx    <= res_idx;
            r_out_status <= res_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out_idx};
    assign m_axis_tuser  = r_out_status;

endmodule

[dv/texture_slot_allocator_tb.sv]
// Testbench for texture_slot_allocator: directed and random add, lookup and end-of-frame
// requests, checked by a slot table predictor. Depends on tsa_pkg and the RTL top level.
`timescale 1ns / 100ps

module texture_slot_allocator_tb;
    import tsa_pkg::*;

    localparam int NUM_SLOTS = 16;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct {
        logic [3:0] slot;
        t_status    status;
    } t_slot_result;

    class slot_scoreboard;
        bit           slot_valid[NUM_SLOTS];
        logic [31:0]  slot_id[NUM_SLOTS];
        bit           slot_rsv[NUM_SLOTS];
        t_slot_result pending_results[$];
        int           errors;

        function int find_holder(logic [31:0] id);
            for (int i = 1; i < NUM_SLOTS; i++) begin
                if (slot_valid[i] && slot_id[i] == id) return i;
            end
            return 0;
        endfunction

        function void bind_slot(int i, logic [31:0] id);
            slot_valid[i] = 1'b1;
            slot_id[i]    = id;
            slot_rsv[i]   = 1'b1;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // Accepted request: update the table and queue the result it produces.
        function void note_request(logic [1:0] act, logic [31:0] id);
            t_slot_result r;
            int hit;
            int empty_slot;
            int free_slot;
            r.slot   = 4'd0;
            r.status = STS_MISS;
            hit = find_holder(id);
            empty_slot = 0;
            free_slot  = 0;
            for (int i = NUM_SLOTS - 1; i >= 1; i--) begin
                if (!slot_valid[i]) empty_slot = i;
                if (!slot_rsv[i]) free_slot = i;
            end
            case (act)
                ACT_ADD: begin
                    if (hit != 0) begin
                        slot_rsv[hit] = 1'b1;
                        r.slot   = hit[3:0];
                        r.status = STS_HIT;
                    end else if (empty_slot != 0) begin
                        bind_slot(empty_slot, id);
                        r.slot   = empty_slot[3:0];
                        r.status = STS_PLACED;
                    end else if (free_slot != 0) begin
                        bind_slot(free_slot, id);
                        r.slot   = free_slot[3:0];
                        r.status = STS_REPLACED;
                    end
                end
                ACT_LOOKUP: begin
                    r.slot   = hit[3:0];
                    r.status = (hit != 0) ? STS_HIT : STS_MISS;
                end
                ACT_END: begin
                    for (int i = 0; i < NUM_SLOTS; i++) slot_rsv[i] = 1'b0;
                    r.status = STS_FRAME;
                end
                default: ;
            endcase
            pending_results.push_back(r);
        endfunction

        function void check_result(logic [7:0] data, logic [2:0] sts);
            t_slot_result r;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual tdata %h status %0d",
                         $time, data, sts);
                return;
            end
            r = pending_results.pop_front();
            if (data !== {4'b0000, r.slot}) begin
                errors++;
                $display("%0t: slot_index mismatch, expected tdata %h, actual %h",
                         $time, {4'b0000, r.slot}, data);
            end
            if (sts !== r.status) begin
                errors++;
                $display("%0t: status mismatch, expected %0d, actual %0d",
                         $time, r.status, sts);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;  // resource_id[31:0]
    logic [1:0]  s_tuser = '0;  // action[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;       // slot_index[3:0], zero[7:4]
    logic [2:0]  m_tuser;       // status[2:0]

    slot_scoreboard sb;
    bit             random_started;
    int             burst_left;
    logic [31:0]    id_pool[24];

    texture_slot_allocator #(.SLOTS(NUM_SLOTS)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
            if (s_tvalid && s_tready) sb.note_request(s_tuser, s_tdata);
        end
    end

    // Offer one request, hold it until the transaction, then maybe idle between bursts.
    task automatic drive_request(logic [1:0] act, logic [31:0] id);
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= id;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 25)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 12);
        end
    endtask

    function automatic logic [31:0] pick_id();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 80) return id_pool[$urandom_range(0, 23)];
        if (sel < 88) return id_pool[$urandom_range(0, 23)] ^ (32'd1 << $urandom_range(0, 31));
        return $urandom;
    endfunction

    function automatic logic [1:0] pick_action(int end_pct);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < end_pct) return ACT_END;
        if (sel < 97 - (97 - end_pct) * 35 / 100) return ACT_LOOKUP;
        if (sel < 97) return ACT_ADD;
        return ACT_UNUSED;
    endfunction

    // Receiver: changing stall patterns, plus one long hold-off during the random phase.
    initial begin
        int mode;
        int cyc;
        int since_start;
        bit hold_done;
        bit rdy;
        cyc = 0;
        since_start = 0;
        hold_done = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(20, 150)) begin
                if (random_started && !hold_done && ++since_start > 60) begin
                    m_tready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                    hold_done = 1'b1;
                end
                case (mode)
                    0: rdy = 1'b1;
                    1: rdy = $urandom_range(0, 1);
                    2: rdy = ($urandom_range(0, 99) < 85);
                    default: rdy = (cyc % 4 == 0);
                endcase
                m_tready <= rdy;
                cyc++;
                @(posedge i_clk);
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin
        int end_pct;
        sb = new();
        burst_left = 0;
        random_started = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, extreme ids, hits, unused code, fill to full, frame end, replace
        drive_request(ACT_LOOKUP, 32'h0000_0000);
        drive_request(ACT_ADD, 32'h0000_0000);
        drive_request(ACT_ADD, 32'hFFFF_FFFF);
        drive_request(ACT_LOOKUP, 32'h0000_0000);
        drive_request(ACT_LOOKUP, 32'hFFFF_FFFF);
        drive_request(ACT_ADD, 32'h0000_0000);
        drive_request(ACT_UNUSED, 32'hFFFF_FFFF);
        for (int k = 0; k < 13; k++) drive_request(ACT_ADD, 32'h5555_5555 << k);
        drive_request(ACT_ADD, 32'h8000_0000);
        drive_request(ACT_END, 32'hFFFF_FFFF);
        drive_request(ACT_ADD, 32'h7FFF_FFFF);
        drive_request(ACT_LOOKUP, 32'h0000_0000);

        foreach (id_pool[i]) id_pool[i] = $urandom;
        random_started = 1'b1;
        for (int seg = 0; seg < 10; seg++) begin
            end_pct = $urandom_range(0, 15);
            repeat (95) drive_request(pick_action(end_pct), pick_id());
        end
        s_tvalid <= 1'b0;

        // let the monitor note the last transaction before draining
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

endmodule

[filelist.f]
design/tsa_pkg.sv
design/tsa_cell.sv
design/texture_slot_allocator.sv
dv/texture_slot_allocator_tb.sv
